FILE: hw/rtl/tsd_pkg.sv
// Package for the temperature seven-segment display unit.
// Holds request/response types, digit codes and the segment table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

   localparam int unsigned NumDigits  = 4;
   localparam int unsigned CodeWidth  = 4;
   localparam int unsigned PosWidth   = 2;

   localparam logic [3:0] CodeMinus = 4'd10;
   localparam logic [3:0] CodeBlank = 4'd11;
   localparam logic [3:0] CodeHalf  = 4'd5;
   localparam logic [3:0] CodeZero  = 4'd0;

   // digit that carries the decimal point (ones)
   localparam logic [1:0] DpDigit = 2'd1;

   localparam logic ReqSample = 1'b0;
   localparam logic ReqScan   = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] temp_sample;
   } tsd_req_type;

   typedef struct packed {
      logic [7:0] segments;
      logic [3:0] digit_select;
   } tsd_rsp_type;

   // index 0 tenths, 1 ones, 2 tens, 3 sign
   typedef logic [NumDigits-1:0][CodeWidth-1:0] tsd_codes_type;

   function automatic logic [7:0] seg_lookup(input logic [3:0] code);
      logic [7:0] seg;
      case (code)
         4'd0:    seg = 8'h3f;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5b;
         4'd3:    seg = 8'h4f;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6d;
         4'd6:    seg = 8'h7c;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7f;
         4'd9:    seg = 8'h67;
         4'd10:   seg = 8'h40;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tsd_digit_conv.sv
// Converts a raw sensor word into sign, tens, ones and tenths digit codes.
// Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_digit_conv (
   input  wire logic [15:0]           temp_sample,
   output tsd_pkg::tsd_codes_type     codes
);

   logic [15:0] mag;
   logic [6:0]  int_part;
   logic [14:0] prod;
   logic [3:0]  quot;
   logic [6:0]  quot_x10;
   logic [6:0]  rem_ones;
   logic [3:0]  tens;

   always_comb begin
      mag = temp_sample[15] ? (~temp_sample + 16'd1) : temp_sample;
      int_part = mag[14:8];
      // ip / 10 as (ip * 205) >> 11, exact for ip below 128
      prod = 15'(int_part) * 15'd205;
      quot = prod[14:11];
      quot_x10 = 7'(quot) * 7'd10;
      rem_ones = int_part - quot_x10;
      // quotient is at most 12, so one subtract gives mod 10
      tens = (quot >= 4'd10) ? (quot - 4'd10) : quot;

      codes[3] = temp_sample[15] ? tsd_pkg::CodeMinus : tsd_pkg::CodeBlank;
      codes[2] = tens;
      codes[1] = rem_ones[3:0];
      codes[0] = mag[7] ? tsd_pkg::CodeHalf : tsd_pkg::CodeZero;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/tsd_mux_core.sv
// Digit store and scan multiplexer: holds the digit codes, the valid flag
// and the scan position; forms the next response. Depends on tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_mux_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  tsd_pkg::tsd_req_type       req,
   input  tsd_pkg::tsd_codes_type     new_codes,
   output tsd_pkg::tsd_rsp_type       rsp
);

   tsd_pkg::tsd_codes_type codes_ff, codes_in;
   logic                   shown_ff, shown_in;
   logic [1:0]             pos_ff, pos_in;
   logic [7:0]             seg;

   always_comb begin
      codes_in = codes_ff;
      shown_in = shown_ff;
      pos_in   = pos_ff;
      seg      = tsd_pkg::seg_lookup(codes_ff[pos_ff]);
      rsp      = '0;
      if (req.req_type == tsd_pkg::ReqSample) begin
         codes_in = new_codes;
         shown_in = 1'b1;
      end else if (shown_ff) begin
         rsp.segments     = (pos_ff == tsd_pkg::DpDigit) ? (seg | 8'h80) : seg;
         rsp.digit_select = 4'b0001 << pos_ff;
         pos_in           = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= '0;
         shown_ff <= 1'b0;
         pos_ff   <= '0;
      end else if (step) begin
         codes_ff <= codes_in;
         shown_ff <= shown_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/temperature_seven_segment_display_unit.sv
// Top level of the temperature seven-segment display unit.
// Instantiates tsd_digit_conv and tsd_mux_core; depends on tsd_pkg.
//
//   Channel | Ports                          | Payload
//   --------+--------------------------------+-------------------------------
//   request | req_valid, req_stall, req_data | req_type, temp_sample
//   result  | rsp_valid, rsp_stall, rsp_data | segments, digit_select
//
// Every request gives one response once it is accepted: it passes through
// the input register and then through the response register.
// A new request is taken every cycle while the result side keeps up.
// Reset clears the digit codes, the valid flag and the scan position.
// A stall on the result side holds both stages and backs up to req_stall.
`timescale 1ns / 1ps
`default_nettype none

module temperature_seven_segment_display_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  tsd_pkg::tsd_req_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tsd_pkg::tsd_rsp_type       rsp_data
);

   logic                   in_valid_ff, in_valid_in;
   tsd_pkg::tsd_req_type   in_data_ff;
   logic                   out_valid_ff, out_valid_in;
   tsd_pkg::tsd_rsp_type   out_data_ff;
   tsd_pkg::tsd_codes_type new_codes;
   tsd_pkg::tsd_rsp_type   next_rsp;
   logic                   out_free;
   logic                   advance;
   logic                   take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   tsd_digit_conv u_conv (
      .temp_sample (in_data_ff.temp_sample),
      .codes       (new_codes)
   );

   tsd_mux_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .req       (in_data_ff),
      .new_codes (new_codes),
      .rsp       (next_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= next_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
